FILE: src/ldre_pkg.sv
package ldre_pkg;

    localparam int INDEX_BITS  = 31;
    localparam int SYMBOL_BITS = 5;

    typedef logic [INDEX_BITS-1:0]  index_t;
    typedef logic [SYMBOL_BITS-1:0] symbol_t;

    // position of the highest set bit, zero for a zero word
    function automatic symbol_t floor_log2(input index_t v);
        symbol_t r;
        r = '0;
        for (int i = 1; i < INDEX_BITS; i++)
        begin
            if (v[i])
            begin
                r = SYMBOL_BITS'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: src/ldre_in_if.sv
interface ldre_in_if;

    logic                  valid;
    logic                  ready;
    ldre_pkg::index_t      index_value;
    logic                  is_last;

    modport source (output valid, output index_value, output is_last, input ready);
    modport sink (input valid, input index_value, input is_last, output ready);

endinterface

FILE: src/ldre_run_if.sv
interface ldre_run_if #(
    parameter int VALUE_BITS = 7,
    parameter int COUNT_BITS = 7
);

    logic                             valid;
    logic                             ready;
    logic [COUNT_BITS+VALUE_BITS-1:0] packed_word;
    ldre_pkg::symbol_t                run_symbol;
    logic [COUNT_BITS-1:0]            run_length;
    logic                             bad_delta;
    logic                             last_run;

    modport source (
        output valid, output packed_word, output run_symbol, output run_length,
        output bad_delta, output last_run, input ready
    );
    modport sink (
        input valid, input packed_word, input run_symbol, input run_length,
        input bad_delta, input last_run, output ready
    );

endinterface

FILE: src/ldre_run_fifo.sv
module ldre_run_fifo #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push0,
    input  logic [WIDTH-1:0] push0_data,
    input  logic             push1,
    input  logic [WIDTH-1:0] push1_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty,
    output logic             room_for_two
);

    localparam int PTR_BITS = $clog2(DEPTH);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [PTR_BITS:0]   count_reg;
    logic [PTR_BITS:0]   count_next;
    logic [PTR_BITS:0]   push_n;
    logic [PTR_BITS-1:0] wr_ptr_plus1;

    assign head_data    = mem[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= (PTR_BITS+1)'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        push_n      = (PTR_BITS+1)'(push0) + (PTR_BITS+1)'(push1);
        wr_ptr_next = wr_ptr_reg + push_n[PTR_BITS-1:0];
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + push_n - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wr_ptr_reg] <= push0_data;
        end
        if (push1)
        begin
            mem[wr_ptr_plus1] <= push1_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/log_delta_run_length_encoder.sv
// Log-delta run-length encoder. Each transfer on items carries one index of an
// increasing sequence; the first index of a sequence gets symbol 0 and every
// later one floor(log2(index - previous index)). Runs of equal symbols leave on
// runs as words (length << VALUE_BITS) + symbol, at most two words per index. A
// non-positive difference gives symbol 0 and sets bad_delta on its run. A run
// that reaches 2^COUNT_BITS - 1 leaves at once, and the index with is_last set
// closes the open run with last_run and starts a new sequence. The block takes
// one index per cycle: an input register feeds one subtract, priority encode
// and compare, and the words go into a four-entry output queue; input stalls
// only while that queue has fewer than two free entries, and a word passes the
// input register and then the output queue on its way out to runs.
module log_delta_run_length_encoder #(
    parameter int VALUE_BITS = 7,
    parameter int COUNT_BITS = 7
) (
    input logic        clk,
    input logic        rst_n,
    ldre_in_if.sink    items,
    ldre_run_if.source runs
);

    localparam int                    SB        = ldre_pkg::SYMBOL_BITS;
    localparam int                    REC_BITS  = SB + COUNT_BITS + 2;
    localparam logic [COUNT_BITS-1:0] MAX_COUNT = {COUNT_BITS{1'b1}};

    ldre_pkg::index_t      idx_reg;
    logic                  last_reg;
    logic                  stage_valid_reg;
    logic                  stage_valid_next;

    ldre_pkg::index_t      prev_reg;
    ldre_pkg::index_t      prev_next;
    ldre_pkg::symbol_t     sym_reg;
    ldre_pkg::symbol_t     sym_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic                  seen_reg;
    logic                  seen_next;

    logic                  accept;
    logic                  process;
    logic                  room_for_two;
    logic                  not_empty;
    ldre_pkg::index_t      diff;
    ldre_pkg::symbol_t     new_sym;
    logic                  new_bad;
    logic                  emit_change;
    logic                  emit_second;
    logic                  full;
    ldre_pkg::symbol_t     run_sym;
    logic [COUNT_BITS-1:0] run_count;
    logic                  run_bad;
    logic [REC_BITS-1:0]   rec_change;
    logic [REC_BITS-1:0]   rec_second;
    logic                  push0;
    logic                  push1;
    logic [REC_BITS-1:0]   push0_data;
    logic [REC_BITS-1:0]   head;

    assign process     = stage_valid_reg && room_for_two;
    assign items.ready = !stage_valid_reg || process;
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (process)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // symbol of the held index
    always_comb
    begin
        diff    = idx_reg - prev_reg;
        new_sym = '0;
        new_bad = 1'b0;
        if (seen_reg)
        begin
            if (idx_reg > prev_reg)
            begin
                new_sym = ldre_pkg::floor_log2(diff);
            end
            else
            begin
                new_bad = 1'b1;
            end
        end
    end

    // run update
    always_comb
    begin
        emit_change = (count_reg != '0) && (new_sym != sym_reg);
        if (count_reg == '0 || emit_change)
        begin
            run_sym   = new_sym;
            run_count = COUNT_BITS'(1);
            run_bad   = new_bad;
        end
        else
        begin
            run_sym   = sym_reg;
            run_count = count_reg + 1'b1;
            run_bad   = bad_reg | new_bad;
        end
        full        = (run_count == MAX_COUNT);
        emit_second = full || last_reg;

        rec_change = {sym_reg, count_reg, bad_reg, 1'b0};
        rec_second = {run_sym, run_count, run_bad, last_reg};

        push0      = process && (emit_change || emit_second);
        push1      = process && emit_change && emit_second;
        push0_data = emit_change ? rec_change : rec_second;

        prev_next  = prev_reg;
        sym_next   = sym_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        seen_next  = seen_reg;
        if (process)
        begin
            if (last_reg)
            begin
                prev_next  = '0;
                sym_next   = '0;
                count_next = '0;
                bad_next   = 1'b0;
                seen_next  = 1'b0;
            end
            else
            begin
                prev_next  = idx_reg;
                seen_next  = 1'b1;
                sym_next   = run_sym;
                count_next = full ? '0 : run_count;
                bad_next   = full ? 1'b0 : run_bad;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= items.index_value;
            last_reg <= items.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            prev_reg        <= '0;
            sym_reg         <= '0;
            count_reg       <= '0;
            bad_reg         <= 1'b0;
            seen_reg        <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            prev_reg        <= prev_next;
            sym_reg         <= sym_next;
            count_reg       <= count_next;
            bad_reg         <= bad_next;
            seen_reg        <= seen_next;
        end
    end

    ldre_run_fifo #(
        .WIDTH (REC_BITS),
        .DEPTH (4)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push0        (push0),
        .push0_data   (push0_data),
        .push1        (push1),
        .push1_data   (rec_second),
        .pop          (runs.valid && runs.ready),
        .head_data    (head),
        .not_empty    (not_empty),
        .room_for_two (room_for_two)
    );

    assign runs.valid       = not_empty;
    assign runs.run_symbol  = head[REC_BITS-1 -: SB];
    assign runs.run_length  = head[COUNT_BITS+1 : 2];
    assign runs.bad_delta   = head[1];
    assign runs.last_run    = head[0];
    assign runs.packed_word = {head[COUNT_BITS+1 : 2],
                               (VALUE_BITS)'(head[REC_BITS-1 -: SB])};

endmodule

FILE: verif/tb_log_delta_run_length_encoder.sv
`timescale 1ns / 100ps

module tb_log_delta_run_length_encoder;

    localparam int VALUE_BITS = 7;
    localparam int COUNT_BITS = 7;
    localparam int WORD_BITS  = COUNT_BITS + VALUE_BITS;
    localparam int MAX_RUN    = (1 << COUNT_BITS) - 1;
    localparam longint unsigned MAX_INDEX = 64'h7FFF_FFFF;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 140;

    typedef enum int {
        SEQ_MIXED,
        SEQ_STEADY,
        SEQ_BROKEN,
        SEQ_NOISE
    } seq_kind_t;

    typedef struct packed {
        ldre_pkg::index_t index;
        logic             last;
        logic             drain;
    } index_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]  word;
        ldre_pkg::symbol_t     symbol;
        logic [COUNT_BITS-1:0] length;
        logic                  bad;
        logic                  last;
    } run_word_t;

    logic clk;
    logic rst_n;

    ldre_in_if items_if ();
    ldre_run_if #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) runs_if ();

    log_delta_run_length_encoder #(
        .VALUE_BITS(VALUE_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .items(items_if),
        .runs (runs_if)
    );

    index_item_t index_queue[$];
    run_word_t   run_queue[$];
    index_item_t next_item;
    run_word_t   want;

    int send_idle_pct;
    int recv_stall_pct;
    logic recv_hold;
    int items_taken;
    int mismatches;

    // encoder state as the testbench sees it
    ldre_pkg::index_t      prev_index;
    ldre_pkg::symbol_t     run_sym;
    logic [COUNT_BITS-1:0] run_count;
    logic                  run_bad;
    logic                  seq_started;

    int send_idle_by_phase[4] = '{0, 49, 0, 17};
    int recv_stall_by_phase[4] = '{0, 0, 49, 17};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("log_delta_run_length_encoder: mismatch");
        $finish;
    end

    task automatic close_run(input logic last);
        run_word_t r;
        r.word   = (WORD_BITS'(run_count) << VALUE_BITS) | WORD_BITS'(run_sym);
        r.symbol = run_sym;
        r.length = run_count;
        r.bad    = run_bad;
        r.last   = last;
        run_queue = {run_queue, r};
    endtask

    task automatic clear_encoder();
        prev_index  = '0;
        run_sym     = '0;
        run_count   = '0;
        run_bad     = 1'b0;
        seq_started = 1'b0;
    endtask

    task automatic encode_index(input ldre_pkg::index_t idx, input logic last);
        ldre_pkg::symbol_t sym;
        logic bad;
        int unsigned diff;
        sym = '0;
        bad = 1'b0;
        if (seq_started)
        begin
            if (idx > prev_index)
            begin
                diff = int'(idx - prev_index);
                sym = ldre_pkg::symbol_t'($clog2(diff + 1) - 1);
            end
            else
            begin
                bad = 1'b1;
            end
        end
        seq_started = 1'b1;
        prev_index = idx;
        if (run_count != 0 && sym != run_sym)
        begin
            close_run(1'b0);
            run_count = '0;
        end
        if (run_count == 0)
        begin
            run_sym = sym;
            run_count = COUNT_BITS'(1);
            run_bad = bad;
        end
        else
        begin
            run_count = run_count + 1'b1;
            run_bad = run_bad | bad;
        end
        if (run_count == MAX_RUN)
        begin
            close_run(last);
            run_count = '0;
            run_bad = 1'b0;
        end
        if (last)
        begin
            if (run_count != 0)
            begin
                close_run(1'b1);
            end
            clear_encoder();
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    task automatic push_item(input ldre_pkg::index_t idx, input logic last,
                             input logic drain);
        index_item_t it;
        it.index = idx;
        it.last  = last;
        it.drain = drain;
        index_queue = {index_queue, it};
    endtask

    // next index whose difference carries the requested symbol, lower if near the top
    function automatic ldre_pkg::index_t next_index(input ldre_pkg::index_t prev,
                                                    input int sym_req);
        longint unsigned room;
        longint unsigned base;
        longint unsigned span;
        int s;
        room = MAX_INDEX - longint'(prev);
        if (room == 0)
        begin
            return prev;
        end
        s = sym_req;
        while ((64'd1 << s) > room)
        begin
            s--;
        end
        base = 64'd1 << s;
        span = base - 1;
        if (span > room - base)
        begin
            span = room - base;
        end
        return ldre_pkg::index_t'(longint'(prev) + base
                                  + longint'($urandom_range(0, int'(span))));
    endfunction

    task automatic add_sequence(input seq_kind_t kind, input int len, input logic drain);
        ldre_pkg::index_t idx;
        int sym;
        int spot;
        if (kind == SEQ_NOISE)
        begin
            for (int k = 0; k < len; k++)
            begin
                push_item(ldre_pkg::index_t'($urandom), logic'($urandom_range(0, 3) == 0),
                          drain && k == 0);
            end
            return;
        end
        idx = ($urandom_range(0, 3) == 0) ? ldre_pkg::index_t'($urandom)
                                          : ldre_pkg::index_t'($urandom_range(0, 4095));
        sym = (len > 60) ? $urandom_range(0, 20) : $urandom_range(0, 30);
        spot = (kind == SEQ_BROKEN) ? $urandom_range(1, len - 1) : -1;
        push_item(idx, len == 1, drain);
        for (int k = 1; k < len; k++)
        begin
            if (k == spot)
            begin
                idx = idx - ldre_pkg::index_t'($urandom_range(0, 15));
            end
            else
            begin
                if (kind != SEQ_STEADY)
                begin
                    sym = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30)
                                                      : $urandom_range(0, 2);
                end
                idx = next_index(idx, sym);
            end
            push_item(idx, k == len - 1, 1'b0);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_if.valid       <= 1'b0;
            items_if.index_value <= '0;
            items_if.is_last     <= 1'b0;
        end
        else
        begin
            if (items_if.valid && items_if.ready)
            begin
                encode_index(items_if.index_value, items_if.is_last);
                items_taken++;
            end
            if (!items_if.valid || items_if.ready)
            begin
                if (index_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct
                    && !(index_queue[0].drain && run_queue.size() > 0))
                begin
                    next_item = index_queue.pop_front();
                    items_if.valid       <= 1'b1;
                    items_if.index_value <= next_item.index;
                    items_if.is_last     <= next_item.last;
                end
                else
                begin
                    items_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runs_if.ready <= 1'b0;
        end
        else
        begin
            if (runs_if.valid && runs_if.ready)
            begin
                if (run_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: run word expected none actual %0h", $time,
                             runs_if.packed_word);
                end
                else
                begin
                    want = run_queue.pop_front();
                    check_field("packed_word", want.word, runs_if.packed_word);
                    check_field("run_symbol", want.symbol, runs_if.run_symbol);
                    check_field("run_length", want.length, runs_if.run_length);
                    check_field("bad_delta", want.bad, runs_if.bad_delta);
                    check_field("last_run", want.last, runs_if.last_run);
                end
            end
            runs_if.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off so the output queue fills and the input stalls
    initial
    begin
        wait (items_taken >= 1);
        @(negedge clk);
        recv_hold = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        recv_hold = 1'b0;
    end

    initial
    begin
        int queued;
        int len;
        int pick;
        logic drain;
        seq_kind_t kind;
        rst_n = 1'b0;
        items_if.valid = 1'b0;
        items_if.index_value = '0;
        items_if.is_last = 1'b0;
        runs_if.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        items_taken = 0;
        mismatches = 0;
        clear_encoder();

        // single-index sequence
        push_item(31'd0, 1'b1, 1'b0);
        // widest difference, repeated and falling indices, symbol change on the last index
        push_item(31'd0, 1'b0, 1'b0);
        push_item(31'h7FFF_FFFF, 1'b0, 1'b0);
        push_item(31'h7FFF_FFFF, 1'b0, 1'b0);
        push_item(31'd5, 1'b0, 1'b0);
        push_item(31'd6, 1'b0, 1'b0);
        push_item(31'd8, 1'b0, 1'b0);
        push_item(31'd9, 1'b1, 1'b0);
        // plain run closed by the last index
        push_item(31'd100, 1'b0, 1'b0);
        push_item(31'd101, 1'b0, 1'b0);
        push_item(31'd102, 1'b1, 1'b0);
        push_item(31'h4000_0000, 1'b0, 1'b0);
        push_item(31'h7FFF_FFFF, 1'b1, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 4; p++)
        begin
            while (index_queue.size() > 0)
            begin
                @(negedge clk);
            end
            send_idle_pct = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            queued = 0;
            drain = (p != 0);
            if (p == 0 || p == 2)
            begin
                // runs around the full count
                len = $urandom_range(MAX_RUN - 1, MAX_RUN + 3);
                add_sequence(SEQ_STEADY, len, 1'b0);
                queued += len;
            end
            while (queued < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    kind = SEQ_MIXED;
                    len = $urandom_range(1, 24);
                end
                else if (pick < 70)
                begin
                    kind = SEQ_STEADY;
                    len = $urandom_range(1, 40);
                end
                else if (pick < 85)
                begin
                    kind = SEQ_BROKEN;
                    len = $urandom_range(2, 16);
                end
                else
                begin
                    kind = SEQ_NOISE;
                    len = $urandom_range(1, 8);
                end
                add_sequence(kind, len, drain);
                drain = 1'b0;
                queued += len;
            end
        end

        while (index_queue.size() > 0 || items_if.valid || run_queue.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("log_delta_run_length_encoder: match");
        end
        else
        begin
            $display("log_delta_run_length_encoder: mismatch");
        end
        $finish;
    end

endmodule
